>>> hdl/mia_pkg.sv
package mia_pkg;

  localparam int unsigned LIMBS    = 8;
  localparam int unsigned W        = 8 * LIMBS;
  localparam int unsigned H        = W / 2;
  localparam int unsigned MOD_W    = 32;
  localparam int unsigned PORT_W   = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  typedef logic [W-1:0] word_t;

endpackage

>>> hdl/multibyte_integer_alu.sv
// channel | valid / ready          | payload
// input   | in_valid_i / in_ready_o  | operation_i, operand_a_i, operand_b_i, or_equal_i
// output  | out_valid_o / out_ready_i | result_o, compare_true_o, divide_by_zero_o
//
// The pipe holds one input stage, one stage for add, subtract, compare and the
// multiplier partial products, one restoring divide step per quotient bit, and
// the output register.
// A new beat can enter every cycle while the pipe advances; the pipe moves as one
// when the output register is empty or being taken; a stall freezes every stage.
// Reset clears the valid bits only.
module multibyte_integer_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 operation_i,
  input  logic [63:0]                operand_a_i,
  input  logic [63:0]                operand_b_i,
  input  logic                       or_equal_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mia_pkg::PORT_W-1:0] result_o,
  output logic                       compare_true_o,
  output logic                       divide_by_zero_o
);
  import mia_pkg::*;

  logic adv;

  // input stage
  logic  in_v_q;
  op_e   in_op_q;
  word_t in_a_q, in_b_q;
  logic  in_oe_q;

  // operand stage
  logic          s1_v_q;
  op_e           s1_op_q;
  word_t         s1_a_q, s1_dvs_q, s1_res_q;
  logic          s1_cmp_q, s1_dz_q;
  word_t         s1_ll_q;
  logic [H-1:0]  s1_lh_q, s1_hl_q;

  // divide stages
  logic  dv_v_q   [W];
  op_e   dv_op_q  [W];
  word_t dv_rem_q [W];
  word_t dv_quo_q [W];
  word_t dv_dvs_q [W];
  word_t dv_res_q [W];
  logic  dv_cmp_q [W];
  logic  dv_dz_q  [W];

  word_t rem_d [W];
  word_t quo_d [W];

  // output register
  logic  out_v_q;
  word_t out_res_q;
  logic  out_cmp_q, out_dz_q;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_op_q <= op_e'(operation_i);
      in_a_q  <= operand_a_i[W-1:0];
      in_b_q  <= operand_b_i[W-1:0];
      in_oe_q <= or_equal_i;
    end
  end

  word_t        mod_w;
  logic [2*H-1:0] pp_ll;
  logic [2*H-1:0] pp_lh, pp_hl;
  word_t        fast_d;
  logic         cmp_d, dz_d;
  word_t        dvs_d;

  always_comb begin
    mod_w  = {{(W-MOD_W){1'b0}}, in_b_q[MOD_W-1:0]};
    pp_ll  = in_a_q[H-1:0] * in_b_q[H-1:0];
    pp_lh  = in_a_q[H-1:0] * in_b_q[W-1:H];
    pp_hl  = in_a_q[W-1:H] * in_b_q[H-1:0];
    fast_d = '0;
    cmp_d  = 1'b0;
    dz_d   = 1'b0;
    dvs_d  = in_b_q;
    case (in_op_q)
      OP_ADD: fast_d = in_a_q + in_b_q;
      OP_SUB: fast_d = in_a_q - in_b_q;
      OP_DIV: dz_d = (in_b_q == '0);
      OP_REM: begin
        dvs_d = mod_w;
        dz_d  = (mod_w == '0);
      end
      OP_CMP: cmp_d = (in_a_q > in_b_q) || (in_a_q == in_b_q && in_oe_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q  <= in_op_q;
      s1_a_q   <= in_a_q;
      s1_dvs_q <= dvs_d;
      s1_res_q <= fast_d;
      s1_cmp_q <= cmp_d;
      s1_dz_q  <= dz_d;
      s1_ll_q  <= pp_ll;
      s1_lh_q  <= pp_lh[H-1:0];
      s1_hl_q  <= pp_hl[H-1:0];
    end
  end

  // finish the low product on entry to the divide chain
  word_t mul_res;
  logic [H-1:0] cross_sum;
  word_t res0;

  always_comb begin
    cross_sum = s1_lh_q + s1_hl_q;
    mul_res   = s1_ll_q + {cross_sum, {H{1'b0}}};
    res0      = (s1_op_q == OP_MUL) ? mul_res : s1_res_q;
  end

  // one restoring step per stage: shift in the next dividend bit, try subtract
  always_comb begin
    for (int k = 0; k < W; k++) begin
      logic [W:0] trial;
      word_t      r_in, q_in, d_in;
      logic       ge;
      r_in = (k == 0) ? '0       : dv_rem_q[(k == 0) ? 0 : k-1];
      q_in = (k == 0) ? s1_a_q   : dv_quo_q[(k == 0) ? 0 : k-1];
      d_in = (k == 0) ? s1_dvs_q : dv_dvs_q[(k == 0) ? 0 : k-1];
      trial = {r_in, q_in[W-1]};
      ge    = (trial >= {1'b0, d_in});
      rem_d[k] = ge ? W'(trial - {1'b0, d_in}) : trial[W-1:0];
      quo_d[k] = {q_in[W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < W; k++) dv_v_q[k] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= s1_v_q;
      for (int k = 1; k < W; k++) dv_v_q[k] <= dv_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_op_q[0]  <= s1_op_q;
      dv_dvs_q[0] <= s1_dvs_q;
      dv_res_q[0] <= res0;
      dv_cmp_q[0] <= s1_cmp_q;
      dv_dz_q[0]  <= s1_dz_q;
      for (int k = 1; k < W; k++) begin
        dv_op_q[k]  <= dv_op_q[k-1];
        dv_dvs_q[k] <= dv_dvs_q[k-1];
        dv_res_q[k] <= dv_res_q[k-1];
        dv_cmp_q[k] <= dv_cmp_q[k-1];
        dv_dz_q[k]  <= dv_dz_q[k-1];
      end
      for (int k = 0; k < W; k++) begin
        dv_rem_q[k] <= rem_d[k];
        dv_quo_q[k] <= quo_d[k];
      end
    end
  end

  word_t out_res_d;

  always_comb begin
    case (dv_op_q[W-1])
      OP_DIV:  out_res_d = dv_dz_q[W-1] ? '0 : dv_quo_q[W-1];
      OP_REM:  out_res_d = dv_dz_q[W-1] ? '0 : dv_rem_q[W-1];
      default: out_res_d = dv_res_q[W-1];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= out_res_d;
      out_cmp_q <= dv_cmp_q[W-1];
      out_dz_q  <= dv_dz_q[W-1];
    end
  end

  assign out_valid_o      = out_v_q;
  assign result_o         = PORT_W'(out_res_q);
  assign compare_true_o   = out_cmp_q;
  assign divide_by_zero_o = out_dz_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_o == '0 && !compare_true_o)
    else $error("zero divisor beat carries a nonzero result");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_o == '0)
    else $error("compare beat carries a nonzero result");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_v_q[W-1]) && $stable(s1_v_q) && $stable(in_v_q))
    else $error("pipe moved during a stall");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mia_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  operation_i = '0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic        or_equal_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [PORT_W-1:0] result_o;
  logic        compare_true_o;
  logic        divide_by_zero_o;

  typedef struct packed {
    logic [63:0] value;
    logic        gt;
    logic        dz;
  } alu_result_t;

  alu_result_t expected_q[$];
  int  error_count = 0;
  bit  sink_idle_on = 1'b1;
  bit  src_idle_on = 1'b1;
  bit  hold_sink = 1'b0;
  int  hold_cycles = 0;

  always #1 clk_i = ~clk_i;

  multibyte_integer_alu dut (.*);

  function automatic alu_result_t compute_alu(logic [2:0] op, logic [63:0] a_in,
                                              logic [63:0] b_in, logic oe);
    alu_result_t r;
    word_t a, b;
    logic [31:0] m;
    a = a_in[W-1:0];
    b = b_in[W-1:0];
    m = b_in[31:0];
    r = '0;
    case (op)
      OP_ADD: r.value = 64'(word_t'(a + b));
      OP_SUB: r.value = 64'(word_t'(a - b));
      OP_MUL: r.value = 64'(word_t'(a * b));
      OP_DIV: if (b == 0) r.dz = 1'b1; else r.value = 64'(a / b);
      OP_REM: if (m == 0) r.dz = 1'b1; else r.value = 64'(a % m);
      OP_CMP: r.gt = (a > b) || (a == b && oe);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Valid stays up after the beat is taken; release_input, or an idle gap before the next beat, drops it.
  task automatic send_beat(logic [2:0] op, logic [63:0] a, logic [63:0] b, logic oe);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    or_equal_i  <= oe;
    expected_q.push_back(compute_alu(op, a, b, oe));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sink side: random stalls, plus a long hold when requested.
  always @(posedge clk_i) begin
    if (hold_sink) begin
      out_ready_i <= 1'b0;
    end else if (sink_idle_on && out_ready_i && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= $urandom_range(1, 19);
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat %h", result_o);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result_o !== exp_r.value) begin
          $error("result: expected %h actual %h", exp_r.value, result_o);
          error_count++;
        end
        if (compare_true_o !== exp_r.gt) begin
          $error("compare_true: expected %b actual %b", exp_r.gt, compare_true_o);
          error_count++;
        end
        if (divide_by_zero_o !== exp_r.dz) begin
          $error("divide_by_zero: expected %b actual %b", exp_r.dz, divide_by_zero_o);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = 64'(v[7:0]);
      2: v = '1 - 64'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [63:0] mx;
    mx = '1;
    for (int op = 0; op < 8; op++) send_beat(3'(op), mx, 64'h1, 1'b0);
    send_beat(OP_ADD, mx, mx, 1'b0);
    send_beat(OP_SUB, 64'h0, 64'h1, 1'b0);
    send_beat(OP_MUL, mx, mx, 1'b1);
    send_beat(OP_DIV, mx, 64'h0, 1'b0);
    send_beat(OP_DIV, 64'h0, mx, 1'b0);
    send_beat(OP_REM, mx, 64'hffff_ffff_0000_0000, 1'b0);
    send_beat(OP_REM, mx, 64'h0000_0000_ffff_ffff, 1'b0);
    send_beat(OP_CMP, mx, mx, 1'b1);
    send_beat(OP_CMP, mx, mx, 1'b0);
    send_beat(OP_CMP, 64'h0, mx, 1'b1);
    send_beat(OP_CMP, mx, 64'h0, 1'b0);
    send_beat(3'd7, 64'h5555, 64'haaaa, 1'b1);
    release_input();
  endtask

  task automatic test_random(int count);
    logic [63:0] a;
    logic [2:0]  op;
    for (int i = 0; i < count; i++) begin
      a = rand_word();
      op = 3'($urandom_range(0, 7));
      // Equal operands are common in compare so or_equal matters.
      send_beat(op, a, ($urandom_range(0, 4) == 0) ? a : rand_word(), 1'($urandom));
    end
    release_input();
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      test_random(120);
      begin
        repeat (300) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(400);
    test_backpressure();
    test_random(400);
    sink_idle_on = 1'b0;
    src_idle_on = 1'b0;
    test_random(110);
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
